// ----- rtl/ceau_pkg.sv -----
// ceau_pkg: item types, addressing mode codes and constants for the
// 6502 effective-address unit; no dependencies
package ceau_pkg;

    typedef struct packed {
        logic       op;
        logic [3:0] mode;
        logic [7:0] operand_low;
        logic [7:0] operand_high;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic       page_penalty;
        logic [7:0] read_data;
    } ceau_in_t;

    typedef struct packed {
        logic        is_final;
        logic [15:0] address;
        logic [7:0]  value;
        logic        extra_cycle;
        logic        bad_mode;
    } ceau_out_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [3:0] MODE_IMM  = 4'd0;
    localparam logic [3:0] MODE_ABS  = 4'd1;
    localparam logic [3:0] MODE_ZP   = 4'd2;
    localparam logic [3:0] MODE_IMPL = 4'd3;
    localparam logic [3:0] MODE_IND  = 4'd4;
    localparam logic [3:0] MODE_ABSX = 4'd5;
    localparam logic [3:0] MODE_ABSY = 4'd6;
    localparam logic [3:0] MODE_ZPX  = 4'd7;
    localparam logic [3:0] MODE_ZPY  = 4'd8;
    localparam logic [3:0] MODE_INDX = 4'd9;
    localparam logic [3:0] MODE_INDY = 4'd10;
    localparam logic [3:0] MODE_ACC  = 4'd11;
    localparam logic [3:0] MODE_REL  = 4'd12;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    localparam logic [15:0] NO_ADDRESS    = 16'hDEAD;
    localparam logic [7:0]  NO_VALUE      = 8'hBE;
    localparam logic [7:0]  PAGE_LOW_MASK = 8'hFF;
    localparam logic [15:0] PAGE_SIZE     = 16'h0100;

endpackage

// ----- rtl/ceau_if.sv -----
// ceau_in_if / ceau_out_if: valid-ready channels for input and result items
// depends on ceau_pkg
interface ceau_in_if
    import ceau_pkg::*;
();
    logic     valid;
    logic     ready;
    ceau_in_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface ceau_out_if
    import ceau_pkg::*;
();
    logic      valid;
    logic      ready;
    ceau_out_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/ceau_datapath.sv -----
// ceau_datapath: address calculation and indirect-sequence state
// depends on ceau_pkg
module ceau_datapath
    import ceau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  ceau_in_t  item,
    output ceau_out_t result
);

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  held_mode_reg, held_mode_next;
    logic [15:0] pointer_address_reg, pointer_address_next;
    logic [7:0]  fetched_low_reg, fetched_low_next;
    logic [7:0]  held_y_reg, held_y_next;
    logic        held_penalty_reg, held_penalty_next;

    logic [15:0] abs16;
    logic [15:0] idx_base;
    logic [7:0]  idx_val;
    logic [16:0] idx_sum;
    logic        crossed;
    logic [7:0]  ptr_low_inc;
    logic [15:0] second_ptr;
    logic [15:0] read_base;

    always_comb
    begin
        abs16 = {item.operand_high, item.operand_low};
        read_base = {item.read_data, fetched_low_reg};
        if (item.op == OP_READ)
        begin
            idx_base = read_base;
            idx_val  = held_y_reg;
        end
        else if (item.mode == MODE_ABSX)
        begin
            idx_base = abs16;
            idx_val  = item.index_x;
        end
        else
        begin
            idx_base = abs16;
            idx_val  = item.index_y;
        end
        idx_sum = {1'b0, idx_base} + {9'b0, idx_val};
        crossed = |((idx_base ^ idx_sum[15:0]) & PAGE_SIZE);
        ptr_low_inc = (pointer_address_reg[7:0] + 8'd1) & PAGE_LOW_MASK;
        if (held_mode_reg == MODE_IND)
            second_ptr = {pointer_address_reg[15:8], ptr_low_inc};
        else
            second_ptr = {8'h00, ptr_low_inc};
    end

    always_comb
    begin
        phase_next           = phase_reg;
        held_mode_next       = held_mode_reg;
        pointer_address_next = pointer_address_reg;
        fetched_low_next     = fetched_low_reg;
        held_y_next          = held_y_reg;
        held_penalty_next    = held_penalty_reg;
        result.is_final      = 1'b1;
        result.address       = NO_ADDRESS;
        result.value         = NO_VALUE;
        result.extra_cycle   = 1'b0;
        result.bad_mode      = 1'b0;

        if (item.op == OP_READ)
        begin
            unique case (phase_reg)
                PH_LOW:
                begin
                    fetched_low_next = item.read_data;
                    phase_next       = PH_HIGH;
                    result.is_final  = 1'b0;
                    result.address   = second_ptr;
                end
                PH_HIGH:
                begin
                    phase_next = PH_IDLE;
                    if (held_mode_reg == MODE_INDY)
                    begin
                        result.address     = idx_sum[15:0];
                        result.extra_cycle = crossed & held_penalty_reg;
                    end
                    else
                    begin
                        result.address = read_base;
                    end
                end
                default:
                begin
                    result.bad_mode = 1'b1;
                end
            endcase
        end
        else
        begin
            phase_next     = PH_IDLE;
            held_mode_next = item.mode;
            unique case (item.mode)
                MODE_IMM, MODE_REL:
                begin
                    result.value = item.operand_low;
                end
                MODE_ABS:
                begin
                    result.address = abs16;
                end
                MODE_ZP:
                begin
                    result.address = {8'h00, item.operand_low};
                end
                MODE_IMPL, MODE_ACC:
                begin
                    result.address = NO_ADDRESS;
                end
                MODE_ABSX, MODE_ABSY:
                begin
                    result.address     = idx_sum[15:0];
                    result.extra_cycle = crossed & item.page_penalty;
                end
                MODE_ZPX:
                begin
                    result.address = {8'h00, item.operand_low + item.index_x};
                end
                MODE_ZPY:
                begin
                    result.address = {8'h00, item.operand_low + item.index_y};
                end
                MODE_IND, MODE_INDX, MODE_INDY:
                begin
                    if (item.mode == MODE_IND)
                        pointer_address_next = abs16;
                    else if (item.mode == MODE_INDX)
                        pointer_address_next = {8'h00, item.operand_low + item.index_x};
                    else
                        pointer_address_next = {8'h00, item.operand_low};
                    held_y_next       = item.index_y;
                    held_penalty_next = item.page_penalty;
                    phase_next        = PH_LOW;
                    result.is_final   = 1'b0;
                    result.address    = pointer_address_next;
                end
                default:
                begin
                    result.bad_mode = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            held_mode_reg       <= 4'd0;
            pointer_address_reg <= 16'd0;
            fetched_low_reg     <= 8'd0;
            held_y_reg          <= 8'd0;
            held_penalty_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            held_mode_reg       <= held_mode_next;
            pointer_address_reg <= pointer_address_next;
            fetched_low_reg     <= fetched_low_next;
            held_y_reg          <= held_y_next;
            held_penalty_reg    <= held_penalty_next;
        end
    end

endmodule

// ----- rtl/cpu_effective_address_unit_top.sv -----
// cpu_effective_address_unit_top: 6502 effective-address unit top level
// depends on ceau_pkg, ceau_if, ceau_datapath
//
// req carries input items: op 0 starts an address calculation for the given
// addressing mode, op 1 returns the byte for the last pointer read request.
// rsp carries exactly one result item per input item, in order: is_final 0
// is a pointer read request (indirect modes issue two), is_final 1 is the
// finished operand with address, value, extra_cycle and bad_mode.
// An accepted item lands in an input register; the address logic then runs
// combinationally from it into the result register. One item per cycle is
// sustained while rsp.ready stays high; the limit is the single pass through
// the address adder into the result register.
// The result register frees itself when rsp.ready is high, so input items
// keep flowing while a result is taken in the same cycle. When the receiver
// stalls, the result holds, the input register fills, and req.ready drops.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// indirect sequence to idle with all held values cleared.
module cpu_effective_address_unit_top
    import ceau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ceau_in_if.sink    req,
    ceau_out_if.source rsp
);

    logic      s1_valid_reg, s1_valid_next;
    ceau_in_t  s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    ceau_out_t out_item_reg;
    ceau_out_t result;
    logic      out_free;
    logic      s1_fire;
    logic      in_fire;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign in_fire   = req.valid && req.ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !rsp.ready);

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    ceau_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= req.item;
        if (s1_fire)
            out_item_reg <= result;
    end

endmodule

// ----- rtl/ceau_checker.sv -----
// ceau_checker: port-level checks on result items, bound to the top level
// depends on ceau_pkg
module ceau_checker
    import ceau_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input ceau_out_t rsp_item
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    a_bad_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.bad_mode |->
            rsp_item.is_final && rsp_item.address == NO_ADDRESS &&
            rsp_item.value == NO_VALUE && !rsp_item.extra_cycle)
        else $error("bad_mode result without default fields");

    a_request_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.is_final |->
            rsp_item.value == NO_VALUE && !rsp_item.extra_cycle && !rsp_item.bad_mode)
        else $error("read request carries operand fields");

    a_extra_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.extra_cycle |->
            rsp_item.is_final && rsp_item.value == NO_VALUE)
        else $error("extra_cycle on a non-address result");

endmodule

bind cpu_effective_address_unit_top ceau_checker u_ceau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);
